// ----- src/fcsrp_pkg.sv -----
// Shared types and constants for the firmware config selector / data port block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fcsrp_pkg;

	// Sizes
	localparam int TABLE_SLOTS_DEF  = 16;
	localparam int STORE_BYTES      = 4096;
	localparam int STORE_AW         = $clog2(STORE_BYTES);
	localparam int MAX_WIDTH_BYTES  = 8;
	localparam int KEY_ACCESS_BYTES = 2;
	localparam int PORT_DATA_BYTES  = 1;
	localparam int DATA_BYTES       = 8;
	localparam int DATA_W           = 8 * DATA_BYTES;

	// Port widths
	localparam int IN_TDATA_W  = 88;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = DATA_W;
	localparam int OUT_TUSER_W = 3;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 4;

	// Operation codes
	localparam logic [1:0] OP_BUS_RD     = 2'd0;
	localparam logic [1:0] OP_BUS_WR     = 2'd1;
	localparam logic [1:0] OP_LOAD_ENTRY = 2'd2;
	localparam logic [1:0] OP_LOAD_BYTE  = 2'd3;

	// Bus regions
	localparam logic [1:0] RG_SELECTOR = 2'd0;
	localparam logic [1:0] RG_DATA     = 2'd1;

	// Result status codes
	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_UNSUP    = 2'd1;
	localparam logic [1:0] STS_MISS     = 2'd2;
	localparam logic [1:0] STS_UNMAPPED = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_BUS_MODE   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DATA_WIDTH = 1'b1;

	// One item table entry (valid bit is kept apart, in flops)
	typedef struct packed {
		logic [15:0] key;
		logic [11:0] base;
		logic [12:0] len;
	} tbl_entry_t;

endpackage

// ----- src/fcsrp_table.sv -----
// Item table: key/base/length memory with one write and one registered read port,
// plus per-slot valid flops cleared by reset. Depends on fcsrp_pkg.
`timescale 1ns / 1ps

module fcsrp_table #(
	parameter int SLOTS = fcsrp_pkg::TABLE_SLOTS_DEF,
	parameter int SW    = $clog2(fcsrp_pkg::TABLE_SLOTS_DEF)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [SW-1:0]        waddr,
	input  fcsrp_pkg::tbl_entry_t wentry,
	input  logic                 wvalid,
	input  logic                 re,
	input  logic [SW-1:0]        raddr,
	output fcsrp_pkg::tbl_entry_t rd_entry,
	output logic                 rd_valid
);
	import fcsrp_pkg::*;

	tbl_entry_t       mem [SLOTS];
	logic [SLOTS-1:0] vld_q;
	tbl_entry_t       rd_entry_q;
	logic             rd_valid_q;

	// Entry storage, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wentry;
		end
		if (re) begin
			rd_entry_q <= mem[raddr];
			rd_valid_q <= vld_q[raddr];
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= wvalid;
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_valid = rd_valid_q;

endmodule

// ----- src/fcsrp_store.sv -----
// Byte store holding item contents: one write port, one registered read port.
// No reset; contents are undefined until loaded. Depends on fcsrp_pkg.
`timescale 1ns / 1ps

module fcsrp_store (
	input  logic                          clk,
	input  logic                          we,
	input  logic [fcsrp_pkg::STORE_AW-1:0] waddr,
	input  logic [7:0]                    wdata,
	input  logic                          re,
	input  logic [fcsrp_pkg::STORE_AW-1:0] raddr,
	output logic [7:0]                    rdata
);
	import fcsrp_pkg::*;

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/fcsrp_shift.sv -----
// Byte-serial collector: read bytes enter at the top and shift down, so after
// eight beats byte 0 sits in the low bits. Depends on fcsrp_pkg.
`timescale 1ns / 1ps

module fcsrp_shift (
	input  logic                        clk,
	input  logic                        clr,
	input  logic                        shift,
	input  logic [7:0]                  din,
	output logic [fcsrp_pkg::DATA_W-1:0] data
);
	import fcsrp_pkg::*;

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (clr) begin
			data_q <= '0;
		end else if (shift) begin
			data_q <= {din, data_q[DATA_W-1:8]};
		end
	end

	assign data = data_q;

endmodule

// ----- src/firmware_config_select_read_port_top.sv -----
// Firmware config selector/data port. One item in flight; s_tready high only when idle.
// Loads and rejected accesses go straight to the finish state. Selector write: a
// slot scan, one slot per cycle. Data read: 8 byte slots through the store read
// port one per cycle. A result may wait in the output register while the next
// beat is taken. Reset (async) clears control, selection, offset and table valid
// bits; the byte store is not cleared.
`timescale 1ns / 1ps

module firmware_config_select_read_port_top #(
	parameter int TABLE_SLOTS = fcsrp_pkg::TABLE_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// fields low to high: region, access_size, write_data, entry_slot, entry_key,
	// entry_base, entry_length, entry_valid, store_addr, store_byte
	input  logic [fcsrp_pkg::IN_TDATA_W-1:0]  s_tdata,
	// fields: opcode
	input  logic [fcsrp_pkg::IN_TUSER_W-1:0]  s_tuser,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// fields: read_data
	output logic [fcsrp_pkg::OUT_TDATA_W-1:0] m_tdata,
	// fields low to high: status, item_selected
	output logic [fcsrp_pkg::OUT_TUSER_W-1:0] m_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic                             cfg_we,
	input  logic [fcsrp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fcsrp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import fcsrp_pkg::*;

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_LOOKUP = 5'b00010,
		S_FETCH  = 5'b00100,
		S_BYTES  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	// Input beat layout, last member in the low bits
	typedef struct packed {
		logic [7:0]  store_byte;
		logic [11:0] store_addr;
		logic        entry_valid;
		logic [12:0] entry_length;
		logic [11:0] entry_base;
		logic [15:0] entry_key;
		logic [3:0]  entry_slot;
		logic [15:0] write_data;
		logic [3:0]  access_size;
		logic [1:0]  region;
	} in_fields_t;

	state_t      state_q;
	in_fields_t  f;
	logic [1:0]  op;
	logic        s_fire;

	logic        bus_mode_q;
	logic [3:0]  data_width_q;

	logic [3:0]  size_q;
	logic [15:0] key_q;
	logic [1:0]  sts_q;

	logic          sel_valid_q;
	logic [SW-1:0] sel_slot_q;
	logic [31:0]   offset_q;

	logic [SW-1:0] scan_q;
	logic          scan_end_q;
	logic          cmp_vld_q;
	logic [SW-1:0] cmp_slot_q;

	logic [3:0]  bcnt_q;
	logic [32:0] pos_q;
	logic        pend_q;
	logic        pend_inr_q;

	logic              m_valid_q;
	logic [DATA_W-1:0] m_data_q;
	logic [1:0]        m_sts_q;
	logic              m_sel_q;

	logic [3:0]  allowed;
	logic        rd_size_ok;
	logic [15:0] bus_key;
	state_t      idle_next;
	logic [1:0]  idle_sts;

	logic          tbl_we;
	tbl_entry_t    tbl_wentry;
	logic          tbl_re;
	logic [SW-1:0] tbl_raddr;
	tbl_entry_t    tbl_rd_entry;
	logic          tbl_rd_valid;
	logic          lk_hit;

	logic                st_we;
	logic                st_re;
	logic [STORE_AW-1:0] st_raddr;
	logic [7:0]          st_rdata;

	logic              issue;
	logic              inr;
	logic              sh_en;
	logic [7:0]        sh_din;
	logic [DATA_W-1:0] sh_data;
	logic              out_free;
	logic [32:0]       off_sum;

	// Input decode
	assign f        = in_fields_t'(s_tdata);
	assign op       = s_tuser;
	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;

	assign allowed    = bus_mode_q ? data_width_q : 4'(PORT_DATA_BYTES);
	assign rd_size_ok = (f.access_size == allowed) && (f.access_size != 4'd0) &&
		(32'(f.access_size) <= MAX_WIDTH_BYTES);
	assign bus_key    = bus_mode_q ? {f.write_data[7:0], f.write_data[15:8]} : f.write_data;

	// Dispatch of an accepted beat: next state and early status
	always_comb begin
		idle_next = S_FINISH;
		idle_sts  = STS_OK;
		case (op)
			OP_BUS_RD: begin
				case (f.region)
					RG_SELECTOR: idle_sts = STS_UNSUP;
					RG_DATA: begin
						if (!rd_size_ok) begin
							idle_sts = STS_UNSUP;
						end else if (sel_valid_q) begin
							idle_next = S_FETCH;
						end
					end
					default: idle_sts = STS_UNMAPPED;
				endcase
			end
			OP_BUS_WR: begin
				case (f.region)
					RG_SELECTOR: begin
						if (32'(f.access_size) != KEY_ACCESS_BYTES) begin
							idle_sts = STS_UNSUP;
						end else begin
							idle_next = S_LOOKUP;
						end
					end
					RG_DATA: idle_sts = STS_UNSUP;
					default: idle_sts = STS_UNMAPPED;
				endcase
			end
			default: ;
		endcase
	end

	// Table port control
	assign tbl_we     = s_fire && (op == OP_LOAD_ENTRY) && (32'(f.entry_slot) < TABLE_SLOTS);
	assign tbl_wentry = '{key: f.entry_key, base: f.entry_base, len: f.entry_length};
	assign tbl_re     = ((state_q == S_LOOKUP) && !scan_end_q) || (state_q == S_FETCH);
	assign tbl_raddr  = (state_q == S_FETCH) ? sel_slot_q : scan_q;
	assign lk_hit     = cmp_vld_q && tbl_rd_valid && (tbl_rd_entry.key == key_q);

	// Store port control: one byte slot per cycle
	assign st_we    = s_fire && (op == OP_LOAD_BYTE) && (32'(f.store_addr) < STORE_BYTES);
	assign issue    = (state_q == S_BYTES) && !bcnt_q[3];
	assign inr      = (bcnt_q < size_q) && (pos_q < 33'(tbl_rd_entry.len));
	assign st_re    = issue && inr;
	assign st_raddr = STORE_AW'(tbl_rd_entry.base) + pos_q[STORE_AW-1:0];

	assign sh_en    = pend_q;
	assign sh_din   = pend_inr_q ? st_rdata : 8'h00;
	assign out_free = !m_valid_q || m_tready;
	assign off_sum  = {1'b0, offset_q} + 33'(size_q);

	fcsrp_table #(
		.SLOTS(TABLE_SLOTS),
		.SW   (SW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (tbl_we),
		.waddr   (SW'(f.entry_slot)),
		.wentry  (tbl_wentry),
		.wvalid  (f.entry_valid),
		.re      (tbl_re),
		.raddr   (tbl_raddr),
		.rd_entry(tbl_rd_entry),
		.rd_valid(tbl_rd_valid)
	);

	fcsrp_store u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(f.store_addr[STORE_AW-1:0]),
		.wdata(f.store_byte),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	fcsrp_shift u_shift (
		.clk  (clk),
		.clr  (s_fire),
		.shift(sh_en),
		.din  (sh_din),
		.data (sh_data)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_mode_q   <= 1'b0;
			data_width_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BUS_MODE:   bus_mode_q   <= cfg_data[0];
				CFG_DATA_WIDTH: data_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			size_q      <= '0;
			key_q       <= '0;
			sts_q       <= STS_OK;
			sel_valid_q <= 1'b0;
			sel_slot_q  <= '0;
			offset_q    <= '0;
			scan_q      <= '0;
			scan_end_q  <= 1'b0;
			cmp_vld_q   <= 1'b0;
			cmp_slot_q  <= '0;
			bcnt_q      <= '0;
			pos_q       <= '0;
			pend_q      <= 1'b0;
			pend_inr_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						size_q  <= f.access_size;
						key_q   <= bus_key;
						sts_q   <= idle_sts;
						state_q <= idle_next;
						if (idle_next == S_LOOKUP) begin
							// new selection: offset and selection clear first
							offset_q    <= '0;
							sel_valid_q <= 1'b0;
							sel_slot_q  <= '0;
							scan_q      <= '0;
							scan_end_q  <= 1'b0;
							cmp_vld_q   <= 1'b0;
						end
					end
				end
				S_LOOKUP: begin
					// issue one slot per cycle, compare the previous one
					if (!scan_end_q) begin
						scan_q     <= scan_q + 1'b1;
						scan_end_q <= (scan_q == LAST_SLOT);
					end
					cmp_vld_q  <= !scan_end_q;
					cmp_slot_q <= scan_q;
					if (lk_hit) begin
						sel_valid_q <= 1'b1;
						sel_slot_q  <= cmp_slot_q;
						sts_q       <= STS_OK;
						state_q     <= S_FINISH;
					end else if (cmp_vld_q && (cmp_slot_q == LAST_SLOT)) begin
						sts_q   <= STS_MISS;
						state_q <= S_FINISH;
					end
				end
				S_FETCH: begin
					bcnt_q  <= '0;
					pos_q   <= {1'b0, offset_q};
					pend_q  <= 1'b0;
					state_q <= S_BYTES;
				end
				S_BYTES: begin
					pend_q     <= issue;
					pend_inr_q <= inr;
					if (issue) begin
						bcnt_q <= bcnt_q + 4'd1;
						pos_q  <= pos_q + 33'd1;
					end else begin
						// last byte shifts in on this edge; advance offset, saturating
						offset_q <= off_sum[32] ? '1 : off_sum[31:0];
						state_q  <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == S_FINISH) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FINISH) && out_free) begin
			m_data_q <= sh_data;
			m_sts_q  <= sts_q;
			m_sel_q  <= sel_valid_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = {m_sel_q, m_sts_q};

	// Checks
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_tready)
		else $error("input taken while an item is in flight");

	a_miss_unselects: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[1:0] == STS_MISS)) |-> !m_tuser[2])
		else $error("key miss reports an item selected");

	a_err_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[1:0] != STS_OK)) |-> (m_tdata == '0))
		else $error("non-ok beat carries read data");

	a_scan_stops: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_LOOKUP) && cmp_vld_q && (cmp_slot_q == LAST_SLOT)) |=>
		(state_q == S_FINISH))
		else $error("slot scan ran past the last slot");

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for firmware_config_select_read_port_top: selector and data
// port accesses, table and byte-store loads, against an in-bench behavioral predictor.
// Depends on fcsrp_pkg and the top level under src/.
`timescale 1ns / 1ps

module tb;
	import fcsrp_pkg::*;

	// Views of the device state: one follows accepted beats, one plans stimulus
	localparam int TRACK = 0;
	localparam int PLAN  = 1;
	localparam logic [1:0] RG_UNMAPPED = 2'd2;
	localparam int SETTLE_CYCLES = TABLE_SLOTS_DEF + 8;

	// One input beat: opcode on top, then the tdata fields from high to low
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  bval;
		logic [11:0] addr;
		logic        valid;
		logic [12:0] len;
		logic [11:0] base;
		logic [15:0] key;
		logic [3:0]  slot;
		logic [15:0] wdata;
		logic [3:0]  size;
		logic [1:0]  region;
	} access_t;

	typedef struct packed {
		logic [63:0] data;
		logic [1:0]  status;
		logic        sel;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [IN_TUSER_W-1:0] s_tuser = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_BUS_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Device state, one copy per view
	bit [15:0] tbl_key   [2][TABLE_SLOTS_DEF];
	bit [11:0] tbl_base  [2][TABLE_SLOTS_DEF];
	bit [12:0] tbl_len   [2][TABLE_SLOTS_DEF];
	bit        tbl_valid [2][TABLE_SLOTS_DEF];
	bit [7:0]  store_mem [2][STORE_BYTES];
	bit        store_set [2][STORE_BYTES];
	bit        sel_valid [2];
	bit [3:0]  sel_slot  [2];
	bit [31:0] rd_offset [2];
	bit        cfg_bus_mode = 1'b0;
	bit [3:0]  cfg_width = 4'd1;

	access_t access_q[$];
	reply_t  due_replies[$];
	access_t beat_cur;
	bit in_taken = 1'b0;
	bit quiet_tail = 1'b0;
	int send_gap = 0;
	int recv_stall = 0;
	int mismatches = 0;
	int booked = 0;

	firmware_config_select_read_port_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [3:0] data_bytes_now();
		return cfg_bus_mode ? cfg_width : 4'(PORT_DATA_BYTES);
	endfunction

	// Behavior of one access on the chosen view; blind flags a read of an unwritten byte
	function automatic void emulate_fw_access(input int who, input access_t a,
			output reply_t rep, output bit blind);
		logic [15:0] key;
		longint unsigned pos;
		int idx;
		bit hit;
		rep = '0;
		blind = 1'b0;
		hit = 1'b0;
		case (a.op)
			OP_BUS_RD: begin
				if (a.region == RG_SELECTOR) begin
					rep.status = STS_UNSUP;
				end else if (a.region == RG_DATA) begin
					if (a.size == data_bytes_now() && a.size >= 1 && a.size <= MAX_WIDTH_BYTES) begin
						if (sel_valid[who]) begin
							for (int i = 0; i < int'(a.size); i++) begin
								pos = longint'(rd_offset[who]) + longint'(i);
								if (pos < tbl_len[who][sel_slot[who]]) begin
									idx = int'((longint'(tbl_base[who][sel_slot[who]]) + pos)
										% STORE_BYTES);
									if (!store_set[who][idx])
										blind = 1'b1;
									rep.data[8*i +: 8] = store_mem[who][idx];
								end
							end
							// offset sticks at all ones
							if (!blind)
								rd_offset[who] = (64'(rd_offset[who]) + 64'(a.size) > 64'hFFFF_FFFF)
									? 32'hFFFF_FFFF : rd_offset[who] + 32'(a.size);
						end
					end else begin
						rep.status = STS_UNSUP;
						rep.data = '0;
					end
				end else begin
					rep.status = STS_UNMAPPED;
				end
			end
			OP_BUS_WR: begin
				if (a.region == RG_SELECTOR) begin
					if (a.size != 4'(KEY_ACCESS_BYTES)) begin
						rep.status = STS_UNSUP;
					end else begin
						// memory-mapped key arrives big-endian
						key = cfg_bus_mode ? {a.wdata[7:0], a.wdata[15:8]} : a.wdata;
						rd_offset[who] = '0;
						sel_valid[who] = 1'b0;
						sel_slot[who] = '0;
						for (int s = 0; s < TABLE_SLOTS_DEF; s++) begin
							if (!hit && tbl_valid[who][s] && tbl_key[who][s] == key) begin
								hit = 1'b1;
								sel_valid[who] = 1'b1;
								sel_slot[who] = 4'(s);
							end
						end
						rep.status = hit ? STS_OK : STS_MISS;
					end
				end else if (a.region == RG_DATA) begin
					rep.status = STS_UNSUP;
				end else begin
					rep.status = STS_UNMAPPED;
				end
			end
			OP_LOAD_ENTRY: begin
				tbl_key[who][a.slot] = a.key;
				tbl_base[who][a.slot] = a.base;
				tbl_len[who][a.slot] = a.len;
				tbl_valid[who][a.slot] = a.valid;
			end
			default: begin
				store_mem[who][a.addr] = a.bval;
				store_set[who][a.addr] = 1'b1;
			end
		endcase
		rep.sel = sel_valid[who];
	endfunction

	// Random beat of the given opcode; callers override the fields that matter
	function automatic access_t mk_access(input logic [1:0] op);
		logic [95:0] raw;
		access_t a;
		raw = {$urandom(), $urandom(), $urandom()};
		a = raw[89:0];
		a.op = op;
		a.region = 2'($urandom_range(0, 2));
		a.size = 4'($urandom_range(1, 8));
		a.len = 13'($urandom_range(0, 4096));
		return a;
	endfunction

	function automatic access_t mk_bus(input logic [1:0] op, input logic [1:0] region,
			input logic [3:0] size, input logic [15:0] wdata);
		access_t a;
		a = mk_access(op);
		a.region = region;
		a.size = size;
		a.wdata = wdata;
		return a;
	endfunction

	function automatic access_t mk_entry(input logic [3:0] slot, input logic [15:0] key,
			input logic [11:0] base, input logic [12:0] len, input logic valid);
		access_t a;
		a = mk_access(OP_LOAD_ENTRY);
		a.slot = slot;
		a.key = key;
		a.base = base;
		a.len = len;
		a.valid = valid;
		return a;
	endfunction

	function automatic access_t mk_byte(input logic [11:0] addr, input logic [7:0] bval);
		access_t a;
		a = mk_access(OP_LOAD_BYTE);
		a.addr = addr;
		a.bval = bval;
		return a;
	endfunction

	// Queue an access unless it would read a store byte never loaded
	function automatic void book_access(input access_t a);
		reply_t r;
		bit blind;
		emulate_fw_access(PLAN, a, r, blind);
		if (!blind) begin
			access_q.push_back(a);
			booked++;
		end
	endfunction

	// Load item bytes and its table entry, select it, then read it out
	function automatic void plan_sequence();
		logic [15:0] key;
		logic [15:0] bus;
		logic [11:0] base;
		logic [11:0] addr;
		logic [12:0] len;
		logic [3:0] slot;
		logic [3:0] rsize;
		int k;
		int span;
		int n;
		k = $urandom_range(0, 11);
		if (k < 8)
			key = 16'h3C00 | 16'(k);
		else if (k == 8)
			key = 16'h0000;
		else if (k == 9)
			key = 16'hFFFF;
		else
			key = 16'($urandom());
		slot = 4'($urandom_range(0, 15));
		base = 12'($urandom_range(0, 4095));
		k = $urandom_range(0, 19);
		if (k == 0)
			len = 13'd0;
		else if (k == 1)
			len = 13'd4096;
		else if (k < 4)
			len = 13'($urandom_range(0, 4096));
		else
			len = 13'($urandom_range(1, 24));
		span = (len < 13'd64) ? int'(len) : 64;
		for (int j = 0; j < span; j++) begin
			addr = 12'((int'(base) + j) % STORE_BYTES);
			if (!store_set[PLAN][addr])
				book_access(mk_byte(addr, 8'($urandom())));
		end
		book_access(mk_entry(slot, key, base, len, $urandom_range(0, 9) != 0));
		if ($urandom_range(0, 4) == 0)
			book_access(mk_access(2'($urandom_range(0, 3))));
		bus = cfg_bus_mode ? {key[7:0], key[15:8]} : key;
		// now and then the key goes out in the wrong byte order
		if ($urandom_range(0, 7) == 0)
			bus = {bus[7:0], bus[15:8]};
		rsize = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(1, 8)) : 4'(KEY_ACCESS_BYTES);
		book_access(mk_bus(OP_BUS_WR, RG_SELECTOR, rsize, bus));
		n = $urandom_range(1, 8);
		for (int j = 0; j < n; j++) begin
			rsize = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(1, 8)) : data_bytes_now();
			book_access(mk_bus(OP_BUS_RD, RG_DATA, rsize, 16'($urandom())));
			if ($urandom_range(0, 15) == 0)
				book_access(mk_access(2'($urandom_range(0, 3))));
		end
	endfunction

	function automatic void plan_random(input int target);
		booked = 0;
		while (booked < target) begin
			if ($urandom_range(0, 99) < 75)
				plan_sequence();
			else
				book_access(mk_access(2'($urandom_range(0, 3))));
		end
	endfunction

	// Wait for the block to drain, then give it time to go fully idle
	task automatic settle();
		while (access_q.size() != 0 || s_tvalid || due_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [3:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			CFG_BUS_MODE: cfg_bus_mode = val[0];
			default: cfg_width = val;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Driver: input beats from the queue, random idle bursts on both sides
	always @(negedge clk) begin
		access_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (s_tvalid && !in_taken) begin
				// beat still pending, hold it
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
				send_gap = $urandom_range(0, 15);
				s_tvalid <= 1'b0;
			end else if (access_q.size() != 0) begin
				nxt = access_q.pop_front();
				beat_cur = nxt;
				s_tdata <= nxt[IN_TDATA_W-1:0];
				s_tuser <= nxt.op;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end

			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
				recv_stall = $urandom_range(0, 15);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: predict on each input beat, check each result beat
	always @(posedge clk) begin
		reply_t want_new;
		reply_t want;
		bit blind;
		in_taken = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				emulate_fw_access(TRACK, beat_cur, want_new, blind);
				due_replies.push_back(want_new);
				in_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				if (due_replies.size() == 0) begin
					$display("%0t: result beat with none due, data %h tuser %h",
						$time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = due_replies.pop_front();
					if (m_tdata !== want.data) begin
						$display("%0t: read_data expected %h got %h", $time, want.data, m_tdata);
						mismatches++;
					end
					if (m_tuser[1:0] !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time, want.status,
							m_tuser[1:0]);
						mismatches++;
					end
					if (m_tuser[2] !== want.sel) begin
						$display("%0t: item_selected expected %0d got %0d", $time, want.sel,
							m_tuser[2]);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		bit phase_mode [5];
		bit [3:0] phase_width [5];
		phase_mode = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
		phase_width = '{4'd8, 4'd1, 4'd8, 4'd3, 4'd2};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: rejected accesses, miss, lowest-slot match, wrap, reload, empty item
		book_access(mk_bus(OP_BUS_RD, RG_SELECTOR, 4'd2, 16'h0000));
		book_access(mk_bus(OP_BUS_RD, RG_DATA, 4'd1, 16'h0000));
		book_access(mk_bus(OP_BUS_WR, RG_DATA, 4'd1, 16'hFFFF));
		book_access(mk_bus(OP_BUS_WR, RG_SELECTOR, 4'd1, 16'h1234));
		book_access(mk_bus(OP_BUS_RD, RG_UNMAPPED, 4'd8, 16'h0000));
		book_access(mk_bus(OP_BUS_WR, RG_UNMAPPED, 4'd2, 16'h1234));
		book_access(mk_bus(OP_BUS_WR, RG_SELECTOR, 4'd2, 16'hFFFF));
		book_access(mk_byte(12'hFFF, 8'hFF));
		book_access(mk_byte(12'h000, 8'h00));
		book_access(mk_byte(12'h001, 8'hA5));
		book_access(mk_byte(12'h002, 8'h5A));
		book_access(mk_entry(4'd0, 16'h1234, 12'd0, 13'd3, 1'b0));
		book_access(mk_entry(4'd5, 16'h1234, 12'hFFF, 13'd3, 1'b1));
		book_access(mk_entry(4'd9, 16'h1234, 12'd0, 13'd4096, 1'b1));
		book_access(mk_bus(OP_BUS_WR, RG_SELECTOR, 4'd2, 16'h1234));
		repeat (4) book_access(mk_bus(OP_BUS_RD, RG_DATA, 4'd1, 16'h0000));
		book_access(mk_bus(OP_BUS_RD, RG_DATA, 4'd8, 16'h0000));
		book_access(mk_entry(4'd5, 16'hFFFF, 12'd4094, 13'd4096, 1'b0));
		book_access(mk_bus(OP_BUS_RD, RG_DATA, 4'd1, 16'h0000));
		book_access(mk_bus(OP_BUS_WR, RG_SELECTOR, 4'd2, 16'hFFFF));
		book_access(mk_bus(OP_BUS_RD, RG_DATA, 4'd1, 16'h0000));
		book_access(mk_entry(4'd15, 16'h0000, 12'd0, 13'd0, 1'b1));
		book_access(mk_bus(OP_BUS_WR, RG_SELECTOR, 4'd2, 16'h0000));
		book_access(mk_bus(OP_BUS_RD, RG_DATA, 4'd1, 16'h0000));
		plan_random(105);

		for (int p = 0; p < 5; p++) begin
			settle();
			write_reg(CFG_BUS_MODE, {3'd0, phase_mode[p]});
			write_reg(CFG_DATA_WIDTH, phase_width[p]);
			if (p == 4)
				quiet_tail = 1'b1;
			plan_random(130);
		end

		settle();
		if (mismatches == 0 && due_replies.size() == 0) begin
			$display("[firmware_config_select_read_port_top] OK");
		end else begin
			$display("[firmware_config_select_read_port_top] ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("[firmware_config_select_read_port_top] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/fcsrp_pkg.sv
src/fcsrp_table.sv
src/fcsrp_store.sv
src/fcsrp_shift.sv
src/firmware_config_select_read_port_top.sv
tb/tb.sv
